FILE: design/sqle_pkg.sv
// sqle_pkg: shared constants, codes and types of the sql literal escaper
// depends on nothing; imported by every other file of the block but sqle_stream_if

package sqle_pkg;

   localparam int MAX_HELD_SPACES = 60;
   localparam int CNT_W           = $clog2(MAX_HELD_SPACES + 1);

   // character codes
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SUB       = 8'h1A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;

   // dialect codes
   typedef logic [2:0] dialect_type;
   localparam dialect_type DIALECT_BACKSLASH       = 3'd0;
   localparam dialect_type DIALECT_QUOTE_DOUBLE    = 3'd1;
   localparam dialect_type DIALECT_NUL_SPACE       = 3'd2;
   localparam dialect_type DIALECT_QUOTE_BACKSLASH = 3'd3;
   localparam dialect_type DIALECT_NUL_DROP        = 3'd4;

   // wrap mode codes
   typedef logic [1:0] wrap_mode_type;
   localparam wrap_mode_type WRAP_NONE  = 2'd0;
   localparam wrap_mode_type WRAP_QUOTE = 2'd1;
   localparam wrap_mode_type WRAP_TRIM  = 2'd2;

   // register indexes of the csr port
   typedef logic csr_index_type;
   localparam csr_index_type CSR_DIALECT   = 1'b0;
   localparam csr_index_type CSR_WRAP_MODE = 1'b1;
   localparam int CSR_DATA_W = 3;

   // one escaped request: up to two bytes
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [1:0] nb;
      logic       last;
   } esc_item_type;

   // one result byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
      logic       trim_overflow;
   } rsp_item_type;

endpackage

FILE: design/sqle_stream_if.sv
// sqle_req_if / sqle_rsp_if: valid-ready channels of the sql literal escaper
// depends on nothing

interface sqle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       has_byte;
   logic       last_in;

   modport source (output valid, output in_byte, output has_byte, output last_in,
                   input ready);
   modport sink   (input valid, input in_byte, input has_byte, input last_in,
                   output ready);
endinterface

interface sqle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_out;
   logic       trim_overflow;

   modport source (output valid, output out_byte, output last_out,
                   output trim_overflow, input ready);
   modport sink   (input valid, input out_byte, input last_out,
                   input trim_overflow, output ready);
endinterface

FILE: design/sqle_escape_decode.sv
// sqle_escape_decode: maps one source byte to its escaped form for the dialect
// depends on sqle_pkg

module sqle_escape_decode
   import sqle_pkg::*;
(
   input  logic [7:0]   in_byte,
   input  logic         has_byte,
   input  logic         last_in,
   input  dialect_type  dialect,
   output esc_item_type item
);

   logic [7:0] esc_char;

   always_comb begin
      case (in_byte)
         CH_NUL:       esc_char = CH_ZERO;
         CH_LF:        esc_char = CH_LOWER_N;
         CH_CR:        esc_char = CH_LOWER_R;
         CH_BACKSLASH: esc_char = CH_BACKSLASH;
         CH_QUOTE:     esc_char = CH_QUOTE;
         CH_DQUOTE:    esc_char = CH_DQUOTE;
         CH_SUB:       esc_char = CH_UPPER_Z;
         default:      esc_char = CH_NUL;
      endcase
   end

   always_comb begin
      item.b0   = in_byte;
      item.b1   = in_byte;
      item.nb   = 2'd1;
      item.last = last_in;
      if (!has_byte) begin
         item.nb = 2'd0;
      end else if (dialect == DIALECT_BACKSLASH) begin
         if (esc_char != CH_NUL) begin
            item.b0 = CH_BACKSLASH;
            item.b1 = esc_char;
            item.nb = 2'd2;
         end
      end else if (dialect > DIALECT_NUL_DROP) begin
         // unused codes pass through
         item.nb = 2'd1;
      end else if (in_byte == CH_QUOTE) begin
         item.nb = 2'd2;
      end else if (in_byte == CH_BACKSLASH && dialect == DIALECT_QUOTE_BACKSLASH) begin
         item.nb = 2'd2;
      end else if (in_byte == CH_NUL && dialect == DIALECT_NUL_SPACE) begin
         item.b0 = CH_SPACE;
      end else if (in_byte == CH_NUL &&
                   (dialect inside {DIALECT_QUOTE_BACKSLASH, DIALECT_NUL_DROP})) begin
         item.nb = 2'd0;
      end
   end

endmodule

FILE: design/sqle_expander.sv
// sqle_expander: item register, result sequencer, held-space count and result register
// depends on sqle_pkg

module sqle_expander
   import sqle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  esc_item_type  in_item,
   input  wrap_mode_type wrap_mode,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_item_type  out_item
);

   esc_item_type item_ff;
   logic         item_valid_ff;
   logic         start_ff, start_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]   idx_ff, idx_in;
   logic         open_done_ff, open_done_in;
   logic         close_done_ff, close_done_in;
   logic         ovf_ff, ovf_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   logic         wrap, trim, adv, act, emit, remaining, item_done;
   logic         open_pend;
   logic [7:0]   cur_byte;
   rsp_item_type emit_item;

   assign wrap = (wrap_mode != WRAP_NONE);
   assign trim = (wrap_mode == WRAP_TRIM);
   assign adv  = !rsp_valid_ff || out_ready;
   assign act  = item_valid_ff && adv;
   assign cur_byte  = (idx_ff == 2'd0) ? item_ff.b0 : item_ff.b1;
   assign open_pend = start_ff && wrap && !open_done_ff;

   always_comb begin
      emit          = 1'b0;
      emit_item     = '{out_byte: CH_SPACE, last_out: 1'b0, trim_overflow: 1'b0};
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      open_done_in  = open_done_ff;
      close_done_in = close_done_ff;
      ovf_in        = ovf_ff;
      if (open_pend) begin
         emit               = 1'b1;
         emit_item.out_byte = CH_QUOTE;
         open_done_in       = 1'b1;
      end else if (idx_ff < item_ff.nb) begin
         if (cur_byte == CH_SPACE && trim) begin
            cnt_in = cnt_ff + CNT_W'(1);
            idx_in = idx_ff + 2'd1;
         end else if (cnt_ff != '0) begin
            emit   = 1'b1;
            cnt_in = cnt_ff - CNT_W'(1);
         end else begin
            emit               = 1'b1;
            emit_item.out_byte = cur_byte;
            idx_in             = idx_ff + 2'd1;
            emit_item.last_out = item_ff.last && !wrap && (idx_in == item_ff.nb);
         end
      end else if (item_ff.last && !trim && cnt_ff != '0) begin
         emit               = 1'b1;
         cnt_in             = cnt_ff - CNT_W'(1);
         emit_item.last_out = !wrap && (cnt_ff == CNT_W'(1));
      end else if (item_ff.last && wrap && !close_done_ff) begin
         emit               = 1'b1;
         emit_item.out_byte = CH_QUOTE;
         emit_item.last_out = 1'b1;
         close_done_in      = 1'b1;
      end else if (!item_ff.last && cnt_ff != '0 &&
                   (ovf_ff || cnt_ff >= CNT_W'(MAX_HELD_SPACES))) begin
         emit                    = 1'b1;
         emit_item.trim_overflow = 1'b1;
         cnt_in                  = cnt_ff - CNT_W'(1);
         ovf_in                  = 1'b1;
      end
   end

   // is there anything left of this request after the current step
   always_comb begin
      remaining = (start_ff && wrap && !open_done_in) ||
                  (idx_in < item_ff.nb) ||
                  (item_ff.last && !trim && cnt_in != '0) ||
                  (item_ff.last && wrap && !close_done_in) ||
                  (!item_ff.last && cnt_in != '0 &&
                   (ovf_in || cnt_in >= CNT_W'(MAX_HELD_SPACES)));
   end

   assign item_done = act && !remaining;
   assign in_ready  = !item_valid_ff || item_done;
   assign start_in  = item_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         start_ff      <= 1'b1;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         open_done_ff  <= 1'b0;
         close_done_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            item_valid_ff <= in_valid;
         end
         if (item_done) begin
            start_ff      <= start_in;
            cnt_ff        <= item_ff.last ? '0 : cnt_in;
            idx_ff        <= '0;
            open_done_ff  <= 1'b0;
            close_done_ff <= 1'b0;
            ovf_ff        <= 1'b0;
         end else if (act) begin
            cnt_ff        <= cnt_in;
            idx_ff        <= idx_in;
            open_done_ff  <= open_done_in;
            close_done_ff <= close_done_in;
            ovf_ff        <= ovf_in;
         end
         if (act && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
      if (act && emit) begin
         rsp_ff <= emit_item;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_HELD_SPACES))
      else $error("held space count beyond bound");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      item_done && item_ff.last |=> cnt_ff == '0 && start_ff)
      else $error("end of string did not clear held spaces");

   a_ovf_is_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.trim_overflow |-> rsp_ff.out_byte == CH_SPACE)
      else $error("overflow flag on a byte that is not a space");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> idx_ff <= item_ff.nb)
      else $error("byte index past escaped bytes");

endmodule

FILE: design/sql_literal_escaper_unit.sv
// sql_literal_escaper_unit: top level of the sql string literal escaper
// depends on sqle_pkg, sqle_stream_if, sqle_escape_decode and sqle_expander
//
// usage
//   req carries one source byte per request (has_byte low for an empty
//   string, last_in on the final request of a string); rsp carries the
//   bytes of the escaped literal, last_out on its final byte and
//   trim_overflow on spaces flushed because the held run hit its bound
//   csr_wr_en/csr_index/csr_wdata write dialect (index 0) and wrap_mode
//   (index 1); write them only while no string is in flight
// timing
//   a request is decoded on entry and held in the item register; each
//   of its result bytes then passes through the result register
//   the single result sequencer yields each result byte of a request in
//   turn: a plain byte passes at one request per cycle while rsp does not
//   stall, an escaped byte or a quote adds a result byte, and a flushed run
//   of held spaces adds one result byte per space (up to sixty)
// reset and stall
//   reset gives dialect 1, wrap_mode 1, no held spaces, a fresh string
//   and empty registers; no clearing pass is needed
//   when rsp stalls the result register holds its byte and the sequencer
//   waits, and req is back-pressured once the item register is busy

module sql_literal_escaper_unit
   import sqle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sqle_req_if.sink          req,
   sqle_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  csr_index_type     csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dialect_type   dialect_ff;
   wrap_mode_type wrap_mode_ff;
   esc_item_type  esc_item;
   rsp_item_type  rsp_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dialect_ff   <= DIALECT_QUOTE_DOUBLE;
         wrap_mode_ff <= WRAP_QUOTE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIALECT:   dialect_ff   <= csr_wdata;
            CSR_WRAP_MODE: wrap_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // escape the request byte on its way into the item register
   sqle_escape_decode u_decode (
      .in_byte  (req.in_byte),
      .has_byte (req.has_byte),
      .last_in  (req.last_in),
      .dialect  (dialect_ff),
      .item     (esc_item)
   );

   // quotes, held spaces and escaped bytes, one result byte per cycle unless rsp stalls
   sqle_expander u_expander (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_item   (esc_item),
      .wrap_mode (wrap_mode_ff),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_item  (rsp_item)
   );

   assign rsp.out_byte      = rsp_item.out_byte;
   assign rsp.last_out      = rsp_item.last_out;
   assign rsp.trim_overflow = rsp_item.trim_overflow;

endmodule

FILE: test/tb.sv
// tb: self-checking testbench of sql_literal_escaper_unit
// depends on sqle_pkg, the sqle_req_if/sqle_rsp_if interfaces and the design files
// drives planned requests and csr writes, predicts every literal byte and checks it

module tb;
   import sqle_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int SETTLE_CYCLES  = 8;      // quiet cycles before a csr write or drain ends
   localparam int END_CYCLES     = 32;     // extra cycles watched after the last byte
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake on either side
   localparam int SEG_ITEMS      = 42;     // least requests per random segment
   localparam int NUM_SEGMENTS   = 8;

   // idle percentages of the traffic phases
   localparam logic [6:0] PCT_NONE  = 7'd0;
   localparam logic [6:0] PCT_HEAVY = 7'd72;
   localparam logic [6:0] PCT_BOTH  = 7'd19;

   // codes outside the defined ranges, used on purpose
   localparam dialect_type   DIALECT_UNUSED_LOW = 3'd5;
   localparam dialect_type   DIALECT_UNUSED_TOP = 3'd7;
   localparam wrap_mode_type WRAP_UNUSED        = 2'd3;

   typedef enum logic [1:0] {
      ACT_REQUEST,
      ACT_CSR_WRITE,
      ACT_DRAIN,
      ACT_PHASE
   } action_kind_type;

   // one planned step of the stimulus
   typedef struct packed {
      action_kind_type         kind;
      logic [7:0]              in_byte;
      logic                    has_byte;
      logic                    last_in;
      csr_index_type           csr_index;
      logic [CSR_DATA_W-1:0]   csr_wdata;
      logic [6:0]              src_idle_pct;
      logic [6:0]              snk_stall_pct;
   } action_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sqle_req_if req_ch ();
   sqle_rsp_if rsp_ch ();

   sql_literal_escaper_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // plan of requests and control steps, filled once at time zero
   action_type   request_plan_q [$];
   // literal bytes still to come out of the block, oldest first
   rsp_item_type literal_q [$];

   logic [6:0] src_idle_pct;
   logic [6:0] snk_stall_pct;
   int         quiet_cycles;
   int         stuck_cycles;
   int         mismatch_count;
   int         planned_requests;

   // predictor copy of the block state and registers
   dialect_type   model_dialect;
   wrap_mode_type model_wrap;
   bit            model_at_start;
   int            model_held;
   int            step_results;

   // ---------------------------------------------------------------- predictor

   function automatic void push_literal(input logic [7:0] b, input logic ovf);
      rsp_item_type r;
      r.out_byte      = b;
      r.last_out      = 1'b0;
      r.trim_overflow = ovf;
      literal_q.push_back(r);
      step_results++;
   endfunction

   // let out every held space, flagged or not
   function automatic void release_spaces(input logic ovf);
      while (model_held > 0) begin
         push_literal(CH_SPACE, ovf);
         model_held--;
      end
   endfunction

   // a space is held back while trimming, anything else first releases the held run
   function automatic void send_escaped(input logic [7:0] b, input bit trimming);
      if (b == CH_SPACE && trimming) begin
         model_held++;
      end else begin
         release_spaces(1'b0);
         push_literal(b, 1'b0);
      end
   endfunction

   function automatic void escape_char(input logic [7:0] c, input bit trimming);
      logic [7:0] esc;
      if (model_dialect == DIALECT_BACKSLASH) begin
         case (c)
            CH_NUL:       esc = CH_ZERO;
            CH_LF:        esc = CH_LOWER_N;
            CH_CR:        esc = CH_LOWER_R;
            CH_BACKSLASH: esc = CH_BACKSLASH;
            CH_QUOTE:     esc = CH_QUOTE;
            CH_DQUOTE:    esc = CH_DQUOTE;
            CH_SUB:       esc = CH_UPPER_Z;
            default:      esc = CH_NUL;
         endcase
         if (esc != CH_NUL) begin
            send_escaped(CH_BACKSLASH, trimming);
            send_escaped(esc, trimming);
         end else begin
            send_escaped(c, trimming);
         end
      end else if (model_dialect > DIALECT_NUL_DROP) begin
         // unused dialect codes pass the byte through
         send_escaped(c, trimming);
      end else if (c == CH_QUOTE) begin
         send_escaped(CH_QUOTE, trimming);
         send_escaped(CH_QUOTE, trimming);
      end else if (c == CH_BACKSLASH && model_dialect == DIALECT_QUOTE_BACKSLASH) begin
         send_escaped(CH_BACKSLASH, trimming);
         send_escaped(CH_BACKSLASH, trimming);
      end else if (c == CH_NUL && model_dialect == DIALECT_NUL_SPACE) begin
         send_escaped(CH_SPACE, trimming);
      end else if (c == CH_NUL && (model_dialect == DIALECT_QUOTE_BACKSLASH ||
                                   model_dialect == DIALECT_NUL_DROP)) begin
         // dropped nul: no byte, held spaces stay held
      end else begin
         send_escaped(c, trimming);
      end
   endfunction

   // works out the literal bytes caused by one accepted request
   function automatic void escape_request(input logic [7:0] c, input logic has,
                                          input logic last);
      bit           wrap;
      bit           trimming;
      rsp_item_type tail;
      wrap         = (model_wrap != WRAP_NONE);
      trimming     = (model_wrap == WRAP_TRIM);
      step_results = 0;
      if (model_at_start && wrap)
         push_literal(CH_QUOTE, 1'b0);
      if (has)
         escape_char(c, trimming);
      if (last) begin
         if (trimming)
            model_held = 0;
         else
            release_spaces(1'b0);
         if (wrap)
            push_literal(CH_QUOTE, 1'b0);
         if (step_results > 0) begin
            tail          = literal_q.pop_back();
            tail.last_out = 1'b1;
            literal_q.push_back(tail);
         end
         model_at_start = 1'b1;
         model_held     = 0;
      end else begin
         if (model_held >= MAX_HELD_SPACES)
            release_spaces(1'b1);
         model_at_start = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------- plan builders

   task automatic plan_request(input logic [7:0] b, input logic has, input logic last);
      action_type a;
      a          = '0;
      a.kind     = ACT_REQUEST;
      a.in_byte  = b;
      a.has_byte = has;
      a.last_in  = last;
      request_plan_q.push_back(a);
      planned_requests++;
   endtask

   task automatic plan_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      action_type a;
      a           = '0;
      a.kind      = ACT_CSR_WRITE;
      a.csr_index = idx;
      a.csr_wdata = data;
      request_plan_q.push_back(a);
   endtask

   task automatic plan_drain();
      action_type a;
      a      = '0;
      a.kind = ACT_DRAIN;
      request_plan_q.push_back(a);
   endtask

   task automatic plan_phase(input logic [6:0] src_pct, input logic [6:0] snk_pct);
      action_type a;
      a               = '0;
      a.kind          = ACT_PHASE;
      a.src_idle_pct  = src_pct;
      a.snk_stall_pct = snk_pct;
      request_plan_q.push_back(a);
   endtask

   // byte mix leaning on the characters that get escaped
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0, 1, 2, 3: return 8'($urandom_range(255));
         4, 5:       return CH_SPACE;
         default: begin
            case ($urandom_range(8))
               0:       return CH_NUL;
               1:       return CH_LF;
               2:       return CH_CR;
               3:       return CH_SUB;
               4:       return CH_DQUOTE;
               5:       return CH_QUOTE;
               6:       return CH_UPPER_Z;
               7:       return CH_BACKSLASH;
               default: return CH_SPACE;
            endcase
         end
      endcase
   endfunction

   // short string with the odd byteless request mixed in
   task automatic plan_random_string();
      int len;
      bit empty_tail;
      len        = $urandom_range(12);
      empty_tail = ($urandom_range(9) == 0);
      if (len == 0) begin
         plan_request(8'($urandom_range(255)), 1'b0, 1'b1);
      end else begin
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(11) == 0)
               plan_request(8'($urandom_range(255)), 1'b0, 1'b0);
            plan_request(pick_byte(), 1'b1, (i == len - 1) && !empty_tail);
         end
         if (empty_tail)
            plan_request(8'($urandom_range(255)), 1'b0, 1'b1);
      end
   endtask

   // long run of spaces around the held-space bound
   task automatic plan_space_run();
      int prefix;
      int spaces;
      int suffix;
      prefix = $urandom_range(2);
      spaces = $urandom_range(MAX_HELD_SPACES + 6, MAX_HELD_SPACES - 2);
      suffix = $urandom_range(2);
      for (int i = 0; i < prefix; i++)
         plan_request(pick_byte(), 1'b1, 1'b0);
      for (int i = 0; i < spaces; i++)
         plan_request(CH_SPACE, 1'b1, (suffix == 0) && (i == spaces - 1));
      for (int i = 0; i < suffix; i++)
         plan_request(pick_byte(), 1'b1, i == suffix - 1);
   endtask

   // ---------------------------------------------------------------- clock

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- driver
   // one request in flight at a time, held until taken; csr writes and drains
   // wait for a quiet block before they act

   always @(posedge clock) begin
      action_type            act;
      logic                  nxt_valid;
      logic [7:0]            nxt_byte;
      logic                  nxt_has;
      logic                  nxt_last;
      logic                  nxt_wr;
      csr_index_type         nxt_idx;
      logic [CSR_DATA_W-1:0] nxt_wdata;
      nxt_valid = req_ch.valid;
      nxt_byte  = req_ch.in_byte;
      nxt_has   = req_ch.has_byte;
      nxt_last  = req_ch.last_in;
      nxt_wr    = 1'b0;
      nxt_idx   = csr_index;
      nxt_wdata = csr_wdata;
      if (reset) begin
         nxt_valid      = 1'b0;
         quiet_cycles   = 0;
         model_dialect  = DIALECT_QUOTE_DOUBLE;
         model_wrap     = WRAP_QUOTE;
         model_at_start = 1'b1;
         model_held     = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            escape_request(req_ch.in_byte, req_ch.has_byte, req_ch.last_in);

         // quiet: nothing owed, nothing offered, nothing on the result side
         if (literal_q.size() == 0 && !req_ch.valid && !rsp_ch.valid)
            quiet_cycles++;
         else
            quiet_cycles = 0;

         if (!req_ch.valid || req_ch.ready) begin
            nxt_valid = 1'b0;
            if (request_plan_q.size() > 0) begin
               act = request_plan_q[0];
               case (act.kind)
                  ACT_PHASE: begin
                     src_idle_pct  = act.src_idle_pct;
                     snk_stall_pct = act.snk_stall_pct;
                     void'(request_plan_q.pop_front());
                  end
                  ACT_DRAIN: begin
                     if (quiet_cycles >= SETTLE_CYCLES)
                        void'(request_plan_q.pop_front());
                  end
                  ACT_CSR_WRITE: begin
                     if (quiet_cycles >= SETTLE_CYCLES) begin
                        nxt_wr    = 1'b1;
                        nxt_idx   = act.csr_index;
                        nxt_wdata = act.csr_wdata;
                        // predictor takes the new setting before any later request
                        if (act.csr_index == CSR_DIALECT)
                           model_dialect = act.csr_wdata[2:0];
                        else
                           model_wrap = act.csr_wdata[1:0];
                        void'(request_plan_q.pop_front());
                     end
                  end
                  default: begin
                     if ($urandom_range(99) >= src_idle_pct) begin
                        nxt_valid = 1'b1;
                        nxt_byte  = act.in_byte;
                        nxt_has   = act.has_byte;
                        nxt_last  = act.last_in;
                        void'(request_plan_q.pop_front());
                     end
                  end
               endcase
            end
         end
      end
      req_ch.valid    <= nxt_valid;
      req_ch.in_byte  <= nxt_byte;
      req_ch.has_byte <= nxt_has;
      req_ch.last_in  <= nxt_last;
      csr_wr_en       <= nxt_wr;
      csr_index       <= nxt_idx;
      csr_wdata       <= nxt_wdata;
   end

   // ---------------------------------------------------------------- monitor
   // every taken byte is checked against the oldest predicted one

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (literal_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected byte: expected none, actual %02h last %0b ovf %0b",
                        $time, rsp_ch.out_byte, rsp_ch.last_out, rsp_ch.trim_overflow);
            end else begin
               want = literal_q.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  mismatch_count++;
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.out_byte, rsp_ch.out_byte);
               end
               if (rsp_ch.last_out !== want.last_out) begin
                  mismatch_count++;
                  $display("%0t: last_out expected %0b actual %0b",
                           $time, want.last_out, rsp_ch.last_out);
               end
               if (rsp_ch.trim_overflow !== want.trim_overflow) begin
                  mismatch_count++;
                  $display("%0t: trim_overflow expected %0b actual %0b",
                           $time, want.trim_overflow, rsp_ch.trim_overflow);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus and end

   initial begin
      dialect_type   seg_dialect [NUM_SEGMENTS];
      wrap_mode_type seg_wrap    [NUM_SEGMENTS];
      int            seg_start;

      // known levels on every input from time zero
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.in_byte  = '0;
      req_ch.has_byte = 1'b0;
      req_ch.last_in  = 1'b0;
      rsp_ch.ready    = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_DIALECT;
      csr_wdata       = '0;
      src_idle_pct    = PCT_NONE;
      snk_stall_pct   = PCT_NONE;
      mismatch_count  = 0;
      stuck_cycles    = 0;
      planned_requests = 0;

      // directed part, starting from the reset setting (quote doubling, wrapped)
      plan_phase(PCT_NONE, PCT_NONE);
      plan_request("a", 1'b1, 1'b0);
      plan_request(CH_QUOTE, 1'b1, 1'b0);
      plan_request("b", 1'b1, 1'b1);
      // empty string gives just the two quotes
      plan_request(8'hA5, 1'b0, 1'b1);

      // backslash style, bare: every escaped character plus the top byte
      plan_csr(CSR_DIALECT, DIALECT_BACKSLASH);
      plan_csr(CSR_WRAP_MODE, CSR_DATA_W'(WRAP_NONE));
      plan_request(8'hFF, 1'b1, 1'b0);
      plan_request(CH_NUL, 1'b1, 1'b0);
      plan_request(CH_LF, 1'b1, 1'b0);
      plan_request(CH_CR, 1'b1, 1'b0);
      plan_request(CH_BACKSLASH, 1'b1, 1'b0);
      plan_request(CH_QUOTE, 1'b1, 1'b0);
      plan_request(CH_DQUOTE, 1'b1, 1'b0);
      plan_request(CH_SUB, 1'b1, 1'b1);

      // nul to space with trimming: trailing spaces vanish, inner ones survive
      plan_csr(CSR_DIALECT, DIALECT_NUL_SPACE);
      plan_csr(CSR_WRAP_MODE, CSR_DATA_W'(WRAP_TRIM));
      plan_request("x", 1'b1, 1'b0);
      plan_request(CH_SPACE, 1'b1, 1'b0);
      plan_request(CH_NUL, 1'b1, 1'b0);
      plan_request(CH_SPACE, 1'b1, 1'b1);
      plan_request(CH_SPACE, 1'b1, 1'b0);
      plan_request("y", 1'b1, 1'b1);

      // bare literal whose final request yields nothing: no byte carries last
      plan_csr(CSR_DIALECT, DIALECT_QUOTE_BACKSLASH);
      plan_csr(CSR_WRAP_MODE, CSR_DATA_W'(WRAP_NONE));
      plan_request(CH_BACKSLASH, 1'b1, 1'b0);
      plan_request(CH_NUL, 1'b1, 1'b1);

      // a dropped nul must not let the held space out
      plan_csr(CSR_DIALECT, DIALECT_NUL_DROP);
      plan_csr(CSR_WRAP_MODE, CSR_DATA_W'(WRAP_TRIM));
      plan_request(CH_SPACE, 1'b1, 1'b0);
      plan_request(CH_NUL, 1'b1, 1'b1);
      plan_drain();

      // spaces held when trimming is switched off mid string come out later
      plan_request(CH_SPACE, 1'b1, 1'b0);
      plan_request(CH_SPACE, 1'b1, 1'b0);
      plan_csr(CSR_WRAP_MODE, CSR_DATA_W'(WRAP_QUOTE));
      plan_request("b", 1'b1, 1'b1);

      // unused dialect and wrap codes
      plan_csr(CSR_DIALECT, DIALECT_UNUSED_TOP);
      plan_csr(CSR_WRAP_MODE, CSR_DATA_W'(WRAP_UNUSED));
      plan_request(CH_QUOTE, 1'b1, 1'b0);
      plan_request(CH_NUL, 1'b1, 1'b0);
      plan_request(CH_BACKSLASH, 1'b1, 1'b1);

      // random part: each segment opens with its own setting and traffic phase
      seg_dialect = '{DIALECT_BACKSLASH, DIALECT_UNUSED_TOP, DIALECT_QUOTE_DOUBLE,
                      DIALECT_NUL_DROP, DIALECT_NUL_SPACE, DIALECT_QUOTE_BACKSLASH,
                      DIALECT_UNUSED_LOW, DIALECT_BACKSLASH};
      seg_wrap    = '{WRAP_TRIM, WRAP_NONE, WRAP_TRIM, WRAP_UNUSED,
                      WRAP_TRIM, WRAP_QUOTE, WRAP_NONE, WRAP_TRIM};
      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         case (seg % 4)
            0:       plan_phase(PCT_NONE, PCT_NONE);
            1:       plan_phase(PCT_HEAVY, PCT_NONE);
            2:       plan_phase(PCT_NONE, PCT_HEAVY);
            default: plan_phase(PCT_BOTH, PCT_BOTH);
         endcase
         plan_csr(CSR_DIALECT, seg_dialect[seg]);
         plan_csr(CSR_WRAP_MODE, CSR_DATA_W'(seg_wrap[seg]));
         seg_start = planned_requests;
         // two trimming segments open with a run of spaces around the held-space bound
         if (seg == 0 || seg == 4)
            plan_space_run();
         while (planned_requests - seg_start < SEG_ITEMS) begin
            plan_random_string();
            if ($urandom_range(11) == 0)
               plan_drain();
            // now and then a fresh setting between strings, upper bits included
            if ($urandom_range(19) == 0) begin
               plan_csr(CSR_DIALECT, CSR_DATA_W'($urandom_range(7)));
               plan_csr(CSR_WRAP_MODE, CSR_DATA_W'($urandom_range(7)));
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for the plan to run out and every predicted byte to arrive
      @(posedge clock);
      while (request_plan_q.size() != 0 || req_ch.valid || literal_q.size() != 0)
         @(posedge clock);
      // watch a while longer for stray bytes
      repeat (END_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && literal_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: sim.f
design/sqle_pkg.sv
design/sqle_stream_if.sv
design/sqle_escape_decode.sv
design/sqle_expander.sv
design/sql_literal_escaper_unit.sv
test/tb.sv
